### hdl/imu_sfp_pkg.sv
// Constants shared by the serial IMU frame parser.
package imu_sfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_RATE   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Byte position: 0 hunts for the header, FRAME_LAST is the checksum byte
  localparam int unsigned POS_W      = 4;
  localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE   = 4'd1;
  localparam logic [POS_W-1:0] FRAME_LAST = 4'd10;

  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned PAYLOAD_IDX_W = 3;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_FS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_FS = 1'b1;

  localparam int unsigned RATE_FS_W  = 12;
  localparam int unsigned ANGLE_FS_W = 8;
  localparam logic [RATE_FS_W-1:0]  RATE_FS_RESET  = 12'd2000;
  localparam logic [ANGLE_FS_W-1:0] ANGLE_FS_RESET = 8'd180;

  // Result kinds carried on tuser
  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  localparam int unsigned RAW_W       = 16;
  localparam int unsigned PROD_W      = RAW_W + RATE_FS_W + 1;
  localparam int unsigned OUT_W       = 21;
  localparam int unsigned SCALE_SHIFT = 15;   // divide by 32768
  localparam int unsigned FULL_TURN_DEG = 360;
  localparam int unsigned M_TDATA_W   = 64;

endpackage

### hdl/imu_serial_frame_parser.sv
// Serial IMU frame parser: byte hunter, checksum and fixed-point scaling.
//
//  port group   dir  width  contents
//  s_axis_*     in   8      received serial byte
//  m_axis_*     out  64+1   scaled triple, kind on tuser
//  cfg_*        in   1+12   full-scale register writes
//
// One byte is taken in every cycle unless the output stalls; the frame state
// advances on each transfer. After its checksum byte a result passes the product
// stage, which registers the three 16x13 products, then the output stage, which
// rounds, wraps yaw and saturates into the output register. The whole pipe stalls
// only while a result waits on m_axis_tready_i. Reset clears the hunter, checksum,
// valid flags and full scales; payload and data registers are written before use.
module imu_serial_frame_parser #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [7:0] rx_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // tdata: [20:0] first_value, [41:21] second_value, [62:42] third_value, [63] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [imu_sfp_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: [0] kind
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [imu_sfp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [imu_sfp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned WideW  = 32 + FRACTION_BITS;
  localparam int unsigned OutW   = imu_sfp_pkg::OUT_W;
  localparam int unsigned ProdW  = imu_sfp_pkg::PROD_W;
  localparam int unsigned PosW   = imu_sfp_pkg::POS_W;
  localparam logic signed [WideW-1:0] RoundHalf =
    WideW'(2 ** (imu_sfp_pkg::SCALE_SHIFT - 1));
  localparam logic signed [WideW-1:0] FullTurn =
    WideW'(imu_sfp_pkg::FULL_TURN_DEG * (2 ** FRACTION_BITS));
  localparam logic signed [WideW-1:0] OutMax = WideW'(2 ** (OutW - 1) - 1);
  localparam logic signed [WideW-1:0] OutMin = -WideW'(2 ** (OutW - 1));

  // Round to nearest (ties upward) after scaling by fs / 32768
  function automatic logic signed [WideW-1:0] round_scaled(
    input logic signed [ProdW-1:0] prod
  );
    logic signed [WideW-1:0] ext;
    ext = WideW'(prod);
    ext = (ext <<< FRACTION_BITS) + RoundHalf;
    return ext >>> imu_sfp_pkg::SCALE_SHIFT;
  endfunction

  function automatic logic signed [OutW-1:0] saturate(input logic signed [WideW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > OutMax) begin
      r = OutMax[OutW-1:0];
    end else if (v < OutMin) begin
      r = OutMin[OutW-1:0];
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [imu_sfp_pkg::RATE_FS_W-1:0]  rate_fs_q;
  logic [imu_sfp_pkg::ANGLE_FS_W-1:0] angle_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_fs_q  <= imu_sfp_pkg::RATE_FS_RESET;
      angle_fs_q <= imu_sfp_pkg::ANGLE_FS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        imu_sfp_pkg::CFG_RATE_FS:  rate_fs_q  <= cfg_wdata_i;
        imu_sfp_pkg::CFG_ANGLE_FS: angle_fs_q <= cfg_wdata_i[imu_sfp_pkg::ANGLE_FS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic m_valid_q;
  logic mid_valid_q;
  logic advance;
  logic s_fire;

  // Pipe moves whenever the output register is empty or being drained
  assign advance         = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign s_fire          = s_axis_tvalid_i && advance;

  // ---------------------------------------------------------------- frame hunter
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      type_q, type_d;
  logic            frame_done;
  logic [7:0]      payload_q [imu_sfp_pkg::PAYLOAD_BYTES];
  logic [PosW-1:0] payload_off;
  logic            payload_we;

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    type_d     = type_q;
    frame_done = 1'b0;
    if (s_fire) begin
      case (pos_q)
        imu_sfp_pkg::POS_HUNT: begin
          if (s_axis_tdata_i == imu_sfp_pkg::HEADER_BYTE) begin
            sum_d = s_axis_tdata_i;
            pos_d = imu_sfp_pkg::POS_TYPE;
          end
        end
        imu_sfp_pkg::POS_TYPE: begin
          type_d = s_axis_tdata_i;
          sum_d  = sum_q + s_axis_tdata_i;
          pos_d  = pos_q + PosW'(1);
        end
        imu_sfp_pkg::FRAME_LAST: begin
          pos_d      = imu_sfp_pkg::POS_HUNT;
          frame_done = 1'b1;
        end
        default: begin
          sum_d = sum_q + s_axis_tdata_i;
          pos_d = pos_q + PosW'(1);
        end
      endcase
    end
  end

  // Data bytes 0..5 sit at positions 2..7; the last two data bytes only feed the sum
  assign payload_off = pos_q - PosW'(2);
  assign payload_we  = s_fire && (pos_q >= PosW'(2)) &&
                       (payload_off < PosW'(imu_sfp_pkg::PAYLOAD_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= imu_sfp_pkg::POS_HUNT;
      sum_q  <= '0;
      type_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      type_q <= type_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (payload_we) begin
      payload_q[payload_off[imu_sfp_pkg::PAYLOAD_IDX_W-1:0]] <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------- multiply stage
  logic        is_rate, is_angle, emit;
  logic [imu_sfp_pkg::RATE_FS_W-1:0] fs_sel;
  logic signed [imu_sfp_pkg::RAW_W-1:0] raw [3];
  logic signed [ProdW-1:0] prod_d [3];
  logic signed [ProdW-1:0] prod_q [3];
  logic        mid_kind_q;

  assign is_rate  = (type_q == imu_sfp_pkg::TYPE_RATE);
  assign is_angle = (type_q == imu_sfp_pkg::TYPE_ANGLE);
  assign emit     = frame_done && (s_axis_tdata_i == sum_q) && (is_rate || is_angle);
  assign fs_sel   = is_angle ? imu_sfp_pkg::RATE_FS_W'(angle_fs_q) : rate_fs_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw[k]    = $signed({payload_q[2*k+1], payload_q[2*k]});
      prod_d[k] = ProdW'(raw[k]) * ProdW'($signed({1'b0, fs_sel}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (advance) begin
      mid_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      prod_q     <= prod_d;
      mid_kind_q <= is_angle ? imu_sfp_pkg::KIND_ANGLE : imu_sfp_pkg::KIND_RATE;
    end
  end

  // ---------------------------------------------------------------- round, wrap, saturate
  logic signed [WideW-1:0] val [3];
  logic signed [WideW-1:0] third_wrapped;
  logic signed [OutW-1:0]  first_q, second_q, third_q;
  logic                    kind_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      val[k] = round_scaled(prod_q[k]);
    end
    third_wrapped = val[2];
    // Bring yaw into one turn; rates pass untouched
    if (mid_kind_q == imu_sfp_pkg::KIND_ANGLE) begin
      if (val[2] > FullTurn) begin
        third_wrapped = val[2] - FullTurn;
      end else if (val[2] < 0) begin
        third_wrapped = val[2] + FullTurn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && mid_valid_q) begin
      first_q  <= saturate(val[0]);
      second_q <= saturate(val[1]);
      third_q  <= saturate(third_wrapped);
      kind_q   <= mid_kind_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, third_q, second_q, first_q};
  assign m_axis_tuser_o  = kind_q;

  // ---------------------------------------------------------------- assertions
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= imu_sfp_pkg::FRAME_LAST)
    else $error("byte position beyond checksum byte");

  a_hunt_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && pos_q == imu_sfp_pkg::POS_HUNT &&
     s_axis_tdata_i != imu_sfp_pkg::HEADER_BYTE) |=> pos_q == imu_sfp_pkg::POS_HUNT)
    else $error("non-header byte left the hunt state");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mid_valid_q) |-> $past(s_fire && pos_q == imu_sfp_pkg::FRAME_LAST))
    else $error("result raised without a checksum byte");

  a_mid_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid_q && !advance) |=> mid_valid_q && $stable(prod_q[0]))
    else $error("product stage lost while stalled");

  a_yaw_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && kind_q == imu_sfp_pkg::KIND_ANGLE) |-> !third_q[OutW-1])
    else $error("wrapped yaw is negative");

endmodule

### tb/sv/tb_imu_serial_frame_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial IMU frame parser: byte stream in, scaled triples out.
module tb_imu_serial_frame_parser;

  localparam int unsigned FRAC_BITS       = 8;
  localparam longint      FRAC_ONE        = longint'(1) << FRAC_BITS;
  localparam longint      FULL_TURN       = longint'(imu_sfp_pkg::FULL_TURN_DEG) * FRAC_ONE;
  localparam longint      OUT_HI          = 1048575;
  localparam longint      OUT_LO          = -1048576;
  localparam int unsigned FRAME_BYTES     = imu_sfp_pkg::FRAME_LAST + 1;
  localparam int unsigned POS_DATA0       = 2;
  localparam int          HALF_PERIOD     = 10;
  localparam int          RESET_CYCLES    = 9;
  // Two pipe stages behind the checksum byte, plus margin for the output register
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam longint      CYCLE_LIMIT     = 400000;

  // One decoded frame as it should leave the block
  typedef struct packed {
    logic                          kind;
    logic [imu_sfp_pkg::OUT_W-1:0] third;
    logic [imu_sfp_pkg::OUT_W-1:0] second;
    logic [imu_sfp_pkg::OUT_W-1:0] first;
  } triple_t;

  // Scoreboard: tracks the frame hunter on every accepted byte, queues the
  // triple that each good frame must produce and checks results in order.
  class imu_frame_predictor;
    logic [imu_sfp_pkg::RATE_FS_W-1:0]  rate_fs;
    logic [imu_sfp_pkg::ANGLE_FS_W-1:0] angle_fs;
    logic [imu_sfp_pkg::POS_W-1:0]      pos;
    logic [7:0]                         sum;
    logic [7:0]                         ftype;
    logic [7:0]                         payload [imu_sfp_pkg::PAYLOAD_BYTES];
    triple_t                            pending [$];
    int unsigned                        mismatches;
    int unsigned                        triples_seen;

    function new();
      rate_fs      = imu_sfp_pkg::RATE_FS_RESET;
      angle_fs     = imu_sfp_pkg::ANGLE_FS_RESET;
      pos          = imu_sfp_pkg::POS_HUNT;
      sum          = 8'h00;
      ftype        = 8'h00;
      foreach (payload[i]) payload[i] = 8'h00;
      mismatches   = 0;
      triples_seen = 0;
    endfunction

    function void set_full_scale(logic [imu_sfp_pkg::CFG_ADDR_W-1:0] addr,
                                 logic [imu_sfp_pkg::CFG_DATA_W-1:0] value);
      if (addr == imu_sfp_pkg::CFG_RATE_FS) rate_fs = value[imu_sfp_pkg::RATE_FS_W-1:0];
      else angle_fs = value[imu_sfp_pkg::ANGLE_FS_W-1:0];
    endfunction

    // Round to nearest, ties upward: add half an LSB, then floor by shifting
    function longint scaled_word(int unsigned k, int unsigned fs);
      longint raw;
      raw = longint'($signed({payload[2*k+1], payload[2*k]}));
      return (raw * longint'(fs) * FRAC_ONE + 16384) >>> imu_sfp_pkg::SCALE_SHIFT;
    endfunction

    function logic [imu_sfp_pkg::OUT_W-1:0] clamp(longint v);
      if (v > OUT_HI) v = OUT_HI;
      else if (v < OUT_LO) v = OUT_LO;
      return v[imu_sfp_pkg::OUT_W-1:0];
    endfunction

    function void take_byte(logic [7:0] b);
      triple_t     t;
      longint      yaw;
      int unsigned d;
      if (pos == imu_sfp_pkg::POS_HUNT) begin
        if (b == imu_sfp_pkg::HEADER_BYTE) begin
          sum = b;
          pos = imu_sfp_pkg::POS_TYPE;
        end
      end else if (pos == imu_sfp_pkg::POS_TYPE) begin
        ftype = b;
        sum   = sum + b;
        pos   = pos + 1;
      end else if (pos < imu_sfp_pkg::FRAME_LAST) begin
        d = pos - POS_DATA0;
        if (d < imu_sfp_pkg::PAYLOAD_BYTES) payload[d] = b;
        sum = sum + b;
        pos = pos + 1;
      end else begin
        pos = imu_sfp_pkg::POS_HUNT;
        if (b == sum && ftype == imu_sfp_pkg::TYPE_RATE) begin
          t.kind   = imu_sfp_pkg::KIND_RATE;
          t.first  = clamp(scaled_word(0, rate_fs));
          t.second = clamp(scaled_word(1, rate_fs));
          t.third  = clamp(scaled_word(2, rate_fs));
          pending.push_back(t);
        end else if (b == sum && ftype == imu_sfp_pkg::TYPE_ANGLE) begin
          yaw = scaled_word(2, angle_fs);
          if (yaw > FULL_TURN) yaw -= FULL_TURN;
          else if (yaw < 0) yaw += FULL_TURN;
          t.kind   = imu_sfp_pkg::KIND_ANGLE;
          t.first  = clamp(scaled_word(0, angle_fs));
          t.second = clamp(scaled_word(1, angle_fs));
          t.third  = clamp(yaw);
          pending.push_back(t);
        end
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_triple(logic [imu_sfp_pkg::M_TDATA_W-1:0] data, logic kind);
      triple_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                 $time, kind, data);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      triples_seen++;
      compare_field("kind", want.kind, kind);
      compare_field("first_value", $signed(want.first),
                    $signed(data[imu_sfp_pkg::OUT_W-1:0]));
      compare_field("second_value", $signed(want.second),
                    $signed(data[2*imu_sfp_pkg::OUT_W-1:imu_sfp_pkg::OUT_W]));
      compare_field("third_value", $signed(want.third),
                    $signed(data[3*imu_sfp_pkg::OUT_W-1:2*imu_sfp_pkg::OUT_W]));
    endfunction
  endclass

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic [7:0]                         s_axis_tdata  = 8'h00;
  logic                               m_axis_tready = 1'b0;
  logic                               cfg_we        = 1'b0;
  logic [imu_sfp_pkg::CFG_ADDR_W-1:0] cfg_addr      = imu_sfp_pkg::CFG_RATE_FS;
  logic [imu_sfp_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;

  logic                               s_axis_tready_o;
  logic                               m_axis_tvalid_o;
  logic [imu_sfp_pkg::M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                               m_axis_tuser_o;

  imu_frame_predictor    decoder;
  int unsigned           bytes_sent   = 0;
  longint                cycle_count  = 0;
  bit                    tx_eager     = 1'b0;
  bit                    rx_eager     = 1'b0;
  bit                    hold_off_req = 1'b0;

  imu_serial_frame_parser #(
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the transfer happens.
  // tvalid stays high into the next byte when the gap is zero.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decoder.take_byte(b);
    bytes_sent++;
  endtask

  // Build an 11-byte frame; a non-zero sum_flip corrupts the checksum
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [7:0] sum_flip);
    logic [7:0] frame_bytes [FRAME_BYTES];
    logic [7:0] sum;
    frame_bytes[0] = imu_sfp_pkg::HEADER_BYTE;
    frame_bytes[1] = ftype;
    frame_bytes[2] = w0[7:0];
    frame_bytes[3] = w0[15:8];
    frame_bytes[4] = w1[7:0];
    frame_bytes[5] = w1[15:8];
    frame_bytes[6] = w2[7:0];
    frame_bytes[7] = w2[15:8];
    // trailing data bytes carry nothing the block uses, but count in the sum
    frame_bytes[8] = 8'($urandom_range(0, 255));
    frame_bytes[9] = 8'($urandom_range(0, 255));
    sum = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + frame_bytes[i];
    frame_bytes[FRAME_BYTES-1] = sum ^ sum_flip;
    // switch between back-to-back bursts and gappy delivery frame by frame
    tx_eager = ($urandom_range(0, 3) == 0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // Lean on the extremes of the signed word, otherwise anything goes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown_type();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255));
    while (t == imu_sfp_pkg::TYPE_RATE || t == imu_sfp_pkg::TYPE_ANGLE);
    return t;
  endfunction

  // Mostly well-formed frames; the rest are bad checksums, unknown types
  // and line noise between frames.
  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  ftype;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      pick  = $urandom_range(0, 99);
      ftype = $urandom_range(0, 1) ? imu_sfp_pkg::TYPE_RATE : imu_sfp_pkg::TYPE_ANGLE;
      if (pick < 72)
        send_frame(ftype, pick_word(), pick_word(), pick_word(), 8'h00);
      else if (pick < 80)
        send_frame(ftype, pick_word(), pick_word(), pick_word(), 8'($urandom_range(1, 255)));
      else if (pick < 87)
        send_frame(pick_unknown_type(), pick_word(), pick_word(), pick_word(), 8'h00);
      else
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stop offering bytes, wait for every queued triple, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoder.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both full-scale registers, rate first then angle; only called while idle
  task automatic set_full_scales(input logic [imu_sfp_pkg::CFG_DATA_W-1:0] rate_value,
                                 input logic [imu_sfp_pkg::CFG_DATA_W-1:0] angle_value);
    cfg_we    <= 1'b1;
    cfg_addr  <= imu_sfp_pkg::CFG_RATE_FS;
    cfg_wdata <= rate_value;
    @(posedge clk_i);
    decoder.set_full_scale(imu_sfp_pkg::CFG_RATE_FS, rate_value);
    cfg_addr  <= imu_sfp_pkg::CFG_ANGLE_FS;
    cfg_wdata <= angle_value;
    @(posedge clk_i);
    decoder.set_full_scale(imu_sfp_pkg::CFG_ANGLE_FS, angle_value);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure, with bursts of always-ready in between.
  // On request, hold off for a long stretch so the pipe backs up into the input.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
      gap = rx_eager ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      decoder.match_triple(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
    end
  end

  initial begin : byte_source
    decoder = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset full scales: noise while hunting must be dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(imu_sfp_pkg::TYPE_RATE);
    // Word extremes, then the header value sitting inside the payload
    send_frame(imu_sfp_pkg::TYPE_RATE, 16'h7FFF, 16'h8000, 16'h0000, 8'h00);
    send_frame(imu_sfp_pkg::TYPE_RATE, 16'hFFFF, 16'h0001, 16'h5555, 8'h00);
    // Negative yaw wraps up by a full turn
    send_frame(imu_sfp_pkg::TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hC000, 8'h00);
    // Exact half-LSB ties on both signs; most negative yaw
    send_frame(imu_sfp_pkg::TYPE_ANGLE, 16'h0010, 16'hFFF0, 16'h8000, 8'h00);
    // Broken checksum and unknown types give nothing; the next frame must still decode
    send_frame(imu_sfp_pkg::TYPE_RATE, 16'h0001, 16'h0002, 16'h0003, 8'h01);
    send_frame(8'h00, 16'h1234, 16'h5678, 16'h9ABC, 8'h00);
    send_frame(imu_sfp_pkg::HEADER_BYTE, 16'h1234, 16'h5678, 16'h9ABC, 8'h00);
    send_frame(imu_sfp_pkg::TYPE_ANGLE, 16'h4000, 16'hC000, 16'h0000, 8'h00);
    random_traffic(250);

    // Smallest non-zero full scales
    drain();
    set_full_scales(12'd1, 12'd1);
    random_traffic(250);

    // Widest register values; starve the result side once so the input stalls
    drain();
    set_full_scales(12'hFFF, 12'h0FF);
    hold_off_req = 1'b1;
    random_traffic(300);

    // Zero full scale flattens everything
    drain();
    set_full_scales(12'd0, 12'd0);
    random_traffic(200);

    // Top of the documented range, with a full pause halfway through
    drain();
    set_full_scales(12'd4000, 12'd180);
    random_traffic(150);
    drain();
    random_traffic(150);

    // Any legal pair
    drain();
    set_full_scales(12'($urandom_range(1, 4000)), 12'($urandom_range(1, 180)));
    random_traffic(400);

    drain();
    $display("Sent %0d bytes; %0d decoded triples checked over six full-scale settings.",
             bytes_sent, decoder.triples_seen);
    $display("Covered noise, bad checksums, unknown types, yaw wrap and input back-pressure.");
    if (decoder.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
